>>> hw/rtl/bb3_pkg.sv
// Shared constants, types and helper functions of the 3x3 box blur unit.
package bb3_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int CFG_W       = 11;
	localparam int CFG_DIM_RST = 1024;

	localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
	localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
	localparam int COL_W  = $clog2(MAX_WIDTH);

	localparam int SUM_W  = 12;
	localparam int CNT_W  = 4;
	localparam int RCP_W  = 17;
	localparam int RCP_SH = 16;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	typedef logic [23:0] pix_t;
	typedef logic [1:0] slot_t;
	// one line store column: three row slots, or window column: top, middle, bottom
	typedef logic [2:0][23:0] col_t;

	typedef struct packed {
		logic  is_pix;
		logic  emit;
		logic  save_col0;
		logic  seed_col0;
		logic  col_first;
		logic  col_last;
		logic  top_ok;
		logic  bot_ok;
		logic  frame_end;
		slot_t slot_top;
		slot_t slot_mid;
		slot_t slot_bot;
		pix_t  pix;
	} tap_ctl_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum_red;
		logic [SUM_W-1:0] sum_green;
		logic [SUM_W-1:0] sum_blue;
		logic [CNT_W-1:0] cnt;
		logic             row_end;
		logic             frame_end;
	} sum_t;

	function automatic slot_t slot_inc(input slot_t s);
		case (s)
			2'd0:    slot_inc = 2'd1;
			2'd1:    slot_inc = 2'd2;
			default: slot_inc = 2'd0;
		endcase
	endfunction

	function automatic slot_t slot_dec(input slot_t s);
		case (s)
			2'd0:    slot_dec = 2'd2;
			2'd1:    slot_dec = 2'd0;
			default: slot_dec = 2'd1;
		endcase
	endfunction

	// Reciprocal scaled by 2^RCP_SH, exact after truncation for sums below 2^SUM_W
	function automatic logic [RCP_W-1:0] rcp_of(input logic [CNT_W-1:0] cnt);
		case (cnt)
			4'd1:    rcp_of = RCP_W'(65536);
			4'd2:    rcp_of = RCP_W'(32768);
			4'd3:    rcp_of = RCP_W'(21846);
			4'd4:    rcp_of = RCP_W'(16384);
			4'd6:    rcp_of = RCP_W'(10923);
			4'd9:    rcp_of = RCP_W'(7282);
			default: rcp_of = RCP_W'(65536);
		endcase
	endfunction

endpackage

>>> hw/rtl/bb3_in_if.sv
// Input channel of the box blur unit: pixels and drain items.
interface bb3_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;

	modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
	modport sink   (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

>>> hw/rtl/bb3_out_if.sv
// Output channel of the box blur unit: blurred pixels with row and frame marks.
interface bb3_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       out_row_end;
	logic       out_frame_end;

	modport source (output valid, out_red, out_green, out_blue, out_row_end, out_frame_end,
		input ready);
	modport sink   (input valid, out_red, out_green, out_blue, out_row_end, out_frame_end,
		output ready);
endinterface

>>> hw/rtl/box_blur_3x3_rgb_unit.sv
// Top level of the streaming 3x3 RGB box blur with edge-normalized averaging.
//
// Channel   Direction  Handshake     Payload
// pixels    in         valid/ready   req_type, in_red, in_green, in_blue
// results   out        valid/ready   out_red, out_green, out_blue, out_row_end, out_frame_end
// cfg       in         cfg_wen       cfg_idx (0 frame_width, 1 frame_height), cfg_wdata
//
// Sustained rate is one item per clock while results are taken; an accepted item passes
// the line store read, the window sum and the reciprocal divide into the output register.
// The first row plus one pixel of a frame give no result; drain items flush the rest.
// Reset clears the counters, the window, the row-start column and all valid flags;
// the line store is not cleared, taps outside the frame are masked instead.
// A stalled result holds the output register; the sum stage, then the window stage,
// then input acceptance back up behind it, one stage at a time.
module box_blur_3x3_rgb_unit
	import bb3_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic             cfg_idx,
	input  logic [CFG_W-1:0] cfg_wdata,
	bb3_in_if.sink           pixels,
	bb3_out_if.source        results
);

	localparam int WCMP_W = (CFG_W > WCNT_W) ? CFG_W : WCNT_W;
	localparam int HCMP_W = (CFG_W > HCNT_W) ? CFG_W : HCNT_W;
	localparam int W_RST  = (CFG_DIM_RST > MAX_WIDTH) ? MAX_WIDTH : CFG_DIM_RST;
	localparam int H_RST  = (CFG_DIM_RST > MAX_HEIGHT) ? MAX_HEIGHT : CFG_DIM_RST;

	// geometry, stored already clamped to 1..MAX
	logic [WCNT_W-1:0] fw_q;
	logic [HCNT_W-1:0] fh_q;
	logic [WCMP_W-1:0] cfg_w_ext;
	logic [HCMP_W-1:0] cfg_h_ext;
	logic [WCNT_W-1:0] cfg_w_eff;
	logic [HCNT_W-1:0] cfg_h_eff;

	// raster positions of the next item to receive and the next result to emit
	logic [COL_W-1:0]  icol_q;
	logic [HCNT_W-1:0] irow_q;
	slot_t             irow_m3_q;
	logic [COL_W-1:0]  ocol_q;
	logic [HCNT_W-1:0] orow_q;
	slot_t             orow_m3_q;

	logic     acc;
	logic     is_pix;
	logic     is_drain;
	logic     frame_done;
	logic     pix_live;
	logic     pix_emit;
	logic     drn_emit;
	logic     emit;
	logic     live;
	logic     icol_last;
	logic     ocol_last;
	logic     orow_last;
	slot_t    bot_slot;
	logic [COL_W-1:0] rd_addr;
	tap_ctl_t ctl_d;

	tap_ctl_t ctl_s1;
	logic     valid_s1;
	col_t     rdata_s1;
	sum_t     sum_d;
	sum_t     sum_s2;
	logic     valid_s2;
	logic     res_valid_q;
	logic     o_free;
	logic     s2_free;
	logic     consume;
	logic     s2_load;
	logic     o_load;

	// clamp register writes: zero counts as one, large values saturate
	always_comb begin
		cfg_w_ext = WCMP_W'(cfg_wdata);
		cfg_h_ext = HCMP_W'(cfg_wdata);
		if (cfg_w_ext == '0) begin
			cfg_w_eff = WCNT_W'(1);
		end else if (cfg_w_ext > WCMP_W'(MAX_WIDTH)) begin
			cfg_w_eff = WCNT_W'(MAX_WIDTH);
		end else begin
			cfg_w_eff = WCNT_W'(cfg_w_ext);
		end
		if (cfg_h_ext == '0) begin
			cfg_h_eff = HCNT_W'(1);
		end else if (cfg_h_ext > HCMP_W'(MAX_HEIGHT)) begin
			cfg_h_eff = HCNT_W'(MAX_HEIGHT);
		end else begin
			cfg_h_eff = HCNT_W'(cfg_h_ext);
		end
	end

	assign acc        = pixels.valid && pixels.ready;
	assign is_pix     = (pixels.req_type == REQ_PIXEL);
	assign is_drain   = (pixels.req_type == REQ_DRAIN);
	assign frame_done = (irow_q >= fh_q);

	// pixels after the frame is complete and drains before it are dropped
	assign pix_live = is_pix && !frame_done;
	assign pix_emit = pix_live && ((irow_q > HCNT_W'(1)) ||
		(irow_q == HCNT_W'(1) && icol_q != '0));
	assign drn_emit = is_drain && frame_done;
	assign emit     = pix_emit || drn_emit;
	assign live     = pix_live || drn_emit;

	assign icol_last = ((WCNT_W'(icol_q) + WCNT_W'(1)) == fw_q);
	assign ocol_last = ((WCNT_W'(ocol_q) + WCNT_W'(1)) == fw_q);
	assign orow_last = ((orow_q + HCNT_W'(1)) == fh_q);

	// The result lags its newest tap by one row plus one pixel, so a pixel item reads
	// its own column. A drain reads the column that pixel would have had: the next
	// output column, or column zero at the end of a row (the next row's start column).
	always_comb begin
		if (is_pix) begin
			bot_slot = irow_m3_q;
			rd_addr  = icol_q;
		end else if (ocol_last) begin
			bot_slot = slot_inc(slot_inc(orow_m3_q));
			rd_addr  = '0;
		end else begin
			bot_slot = slot_inc(orow_m3_q);
			rd_addr  = COL_W'(ocol_q + COL_W'(1));
		end
	end

	always_comb begin
		ctl_d.is_pix    = is_pix;
		ctl_d.emit      = emit;
		ctl_d.save_col0 = (pix_live && icol_q == '0) || (drn_emit && ocol_last);
		ctl_d.seed_col0 = is_pix && (irow_q == '0);
		ctl_d.col_first = (ocol_q == '0);
		ctl_d.col_last  = ocol_last;
		ctl_d.top_ok    = (orow_q != '0);
		ctl_d.bot_ok    = !orow_last;
		ctl_d.frame_end = ocol_last && orow_last;
		ctl_d.slot_bot  = bot_slot;
		ctl_d.slot_mid  = slot_dec(bot_slot);
		ctl_d.slot_top  = slot_inc(bot_slot);
		ctl_d.pix       = {pixels.in_red, pixels.in_green, pixels.in_blue};
	end

	// geometry and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q      <= WCNT_W'(W_RST);
			fh_q      <= HCNT_W'(H_RST);
			icol_q    <= '0;
			irow_q    <= '0;
			irow_m3_q <= '0;
			ocol_q    <= '0;
			orow_q    <= '0;
			orow_m3_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_FRAME_WIDTH: begin
					fw_q <= cfg_w_eff;
				end
				CFG_FRAME_HEIGHT: begin
					fh_q <= cfg_h_eff;
				end
				default: begin
				end
			endcase
			// any register write restarts the frame
			icol_q    <= '0;
			irow_q    <= '0;
			irow_m3_q <= '0;
			ocol_q    <= '0;
			orow_q    <= '0;
			orow_m3_q <= '0;
		end else if (acc) begin
			if (emit) begin
				if (!ocol_last) begin
					ocol_q <= COL_W'(ocol_q + COL_W'(1));
				end else begin
					ocol_q <= '0;
					if (orow_last) begin
						orow_q    <= '0;
						orow_m3_q <= '0;
					end else begin
						orow_q    <= orow_q + HCNT_W'(1);
						orow_m3_q <= slot_inc(orow_m3_q);
					end
				end
			end
			if (pix_live) begin
				if (!icol_last) begin
					icol_q <= COL_W'(icol_q + COL_W'(1));
				end else begin
					icol_q    <= '0;
					irow_q    <= irow_q + HCNT_W'(1);
					irow_m3_q <= slot_inc(irow_m3_q);
				end
			end else if (drn_emit && ocol_last && orow_last) begin
				// last result of the frame: rearm for the next frame
				icol_q    <= '0;
				irow_q    <= '0;
				irow_m3_q <= '0;
			end
		end
	end

	// stage handshake: advance a stage when the one after it is free or moving
	assign o_free         = !res_valid_q || results.ready;
	assign s2_free        = !valid_s2 || o_free;
	assign consume        = valid_s1 && (!ctl_s1.emit || s2_free);
	assign s2_load        = consume && ctl_s1.emit;
	assign o_load         = valid_s2 && o_free;
	assign pixels.ready   = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (acc && live) begin
				valid_s1 <= 1'b1;
			end else if (consume) begin
				valid_s1 <= 1'b0;
			end
			valid_s2    <= s2_load || (valid_s2 && !o_free);
			res_valid_q <= o_load || (res_valid_q && !results.ready);
		end
	end

	// hold stage payloads until the stage advances
	always_ff @(posedge clk) begin
		if (acc && live) begin
			ctl_s1 <= ctl_d;
		end
		if (s2_load) begin
			sum_s2 <= sum_d;
		end
	end

	bb3_line_mem u_line_mem (
		.clk      (clk),
		.wen      (acc && pix_live),
		.waddr    (icol_q),
		.wslot    (irow_m3_q),
		.wdata    (ctl_d.pix),
		.ren      (acc && live),
		.raddr    (rd_addr),
		.rdata_s1 (rdata_s1)
	);

	bb3_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.consume  (consume),
		.ctl_s1   (ctl_s1),
		.rdata_s1 (rdata_s1),
		.sum_d    (sum_d)
	);

	bb3_divide u_divide (
		.clk       (clk),
		.load      (o_load),
		.sum_s2    (sum_s2),
		.red       (results.out_red),
		.green     (results.out_green),
		.blue      (results.out_blue),
		.row_end   (results.out_row_end),
		.frame_end (results.out_frame_end)
	);

	assign results.valid = res_valid_q;

endmodule

>>> hw/rtl/bb3_line_mem.sv
// Line store: one entry per column holding three row slots, slot-wide writes.
module bb3_line_mem
	import bb3_pkg::*;
(
	input  logic             clk,
	input  logic             wen,
	input  logic [COL_W-1:0] waddr,
	input  slot_t            wslot,
	input  pix_t             wdata,
	input  logic             ren,
	input  logic [COL_W-1:0] raddr,
	output col_t             rdata_s1
);

	col_t mem_q [MAX_WIDTH];

	// read returns the entry as it was before this cycle's write
	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr][wslot] <= wdata;
		end
		if (ren) begin
			rdata_s1 <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/bb3_window.sv
// 3x3 window: shift in the new column, keep the row-start column, sum the taps.
module bb3_window
	import bb3_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     consume,
	input  tap_ctl_t ctl_s1,
	input  col_t     rdata_s1,
	output sum_t     sum_d
);

	col_t win_l_q;
	col_t win_c_q;
	col_t win_r_q;
	col_t col0_q;
	col_t fresh;
	col_t nxt_l;
	col_t nxt_c;
	col_t nxt_r;
	logic [1:0] nrows;
	logic [1:0] ncols;

	always_comb begin
		fresh[0] = rdata_s1[ctl_s1.slot_top];
		fresh[1] = rdata_s1[ctl_s1.slot_mid];
		// the bottom row of a pixel item is the pixel itself, its slot is stale
		fresh[2] = ctl_s1.is_pix ? ctl_s1.pix : rdata_s1[ctl_s1.slot_bot];
		nxt_l    = ctl_s1.col_first ? '0 : win_c_q;
		nxt_c    = ctl_s1.col_first ? col0_q : win_r_q;
		nxt_r    = ctl_s1.col_last ? '0 : fresh;
	end

	assign nrows = 2'd1 + {1'b0, ctl_s1.top_ok} + {1'b0, ctl_s1.bot_ok};
	assign ncols = 2'd1 + {1'b0, !ctl_s1.col_first} + {1'b0, !ctl_s1.col_last};

	always_comb begin : sum_blk
		pix_t             tap;
		logic [SUM_W-1:0] acc_r;
		logic [SUM_W-1:0] acc_g;
		logic [SUM_W-1:0] acc_b;
		acc_r = '0;
		acc_g = '0;
		acc_b = '0;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				tap = (k == 0) ? nxt_l[j] : ((k == 1) ? nxt_c[j] : nxt_r[j]);
				if ((j == 0 && !ctl_s1.top_ok) || (j == 2 && !ctl_s1.bot_ok)) begin
					tap = '0;
				end
				acc_r = acc_r + SUM_W'(tap[23:16]);
				acc_g = acc_g + SUM_W'(tap[15:8]);
				acc_b = acc_b + SUM_W'(tap[7:0]);
			end
		end
		sum_d.sum_red   = acc_r;
		sum_d.sum_green = acc_g;
		sum_d.sum_blue  = acc_b;
		sum_d.cnt       = CNT_W'({2'b00, nrows} * {2'b00, ncols});
		sum_d.row_end   = ctl_s1.col_last;
		sum_d.frame_end = ctl_s1.frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_l_q <= '0;
			win_c_q <= '0;
			win_r_q <= '0;
			col0_q  <= '0;
		end else if (consume) begin
			if (ctl_s1.emit) begin
				win_l_q <= nxt_l;
				win_c_q <= nxt_c;
				win_r_q <= nxt_r;
			end
			// first pixel of a frame seeds the middle row for single-row frames
			if (ctl_s1.save_col0) begin
				col0_q <= ctl_s1.seed_col0 ? {3{ctl_s1.pix}} : fresh;
			end
		end
	end

endmodule

>>> hw/rtl/bb3_divide.sv
// Rounded division of the window sums by the tap count, into the output register.
module bb3_divide
	import bb3_pkg::*;
(
	input  logic       clk,
	input  logic       load,
	input  sum_t       sum_s2,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       row_end,
	output logic       frame_end
);

	localparam int PROD_W = SUM_W + RCP_W;

	logic [RCP_W-1:0]  rcp;
	logic [SUM_W-1:0]  half;
	logic [SUM_W-1:0]  num_r;
	logic [SUM_W-1:0]  num_g;
	logic [SUM_W-1:0]  num_b;
	logic [PROD_W-1:0] prod_r;
	logic [PROD_W-1:0] prod_g;
	logic [PROD_W-1:0] prod_b;
	logic [7:0]        red_q;
	logic [7:0]        green_q;
	logic [7:0]        blue_q;
	logic              row_end_q;
	logic              frame_end_q;

	assign rcp  = rcp_of(sum_s2.cnt);
	assign half = SUM_W'(sum_s2.cnt >> 1);

	// round half up: add half the count before the reciprocal multiply
	assign num_r  = sum_s2.sum_red + half;
	assign num_g  = sum_s2.sum_green + half;
	assign num_b  = sum_s2.sum_blue + half;
	assign prod_r = PROD_W'(num_r) * PROD_W'(rcp);
	assign prod_g = PROD_W'(num_g) * PROD_W'(rcp);
	assign prod_b = PROD_W'(num_b) * PROD_W'(rcp);

	always_ff @(posedge clk) begin
		if (load) begin
			red_q       <= prod_r[RCP_SH +: 8];
			green_q     <= prod_g[RCP_SH +: 8];
			blue_q      <= prod_b[RCP_SH +: 8];
			row_end_q   <= sum_s2.row_end;
			frame_end_q <= sum_s2.frame_end;
		end
	end

	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

endmodule
